>>> src/psprq_pkg.sv
// ============================================================================
// psprq_pkg
// Shared types and codes for the process slot pool and ready queue block.
// ============================================================================
package psprq_pkg;

    localparam int SLOT_W = 3;

    typedef enum logic [1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_APPEND  = 2'd2,
        ACT_POP     = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [SLOT_W-1:0]   slot;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_out;
        logic                ok;
    } out_word_t;

    // Commands to the taken-bit tracker.
    typedef struct packed {
        logic alloc;
        logic free;
    } taken_cmd_t;

endpackage

>>> src/psprq_link_ram.sv
// ============================================================================
// psprq_link_ram
// Single write port, single read port link memory with a registered read.
// ============================================================================
module psprq_link_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 3
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/psprq_alloc.sv
// ============================================================================
// psprq_alloc
// Taken bits of the slot pool and a registered lowest-free-slot search.
// ============================================================================
module psprq_alloc #(
    parameter int POOL_SIZE = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psprq_pkg::taken_cmd_t        cmd,
    input  logic [$clog2(POOL_SIZE)-1:0] free_idx,
    output logic [$clog2(POOL_SIZE)-1:0] first_free,
    output logic                         any_free
);
    import psprq_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);

    logic [POOL_SIZE-1:0] taken_reg;
    logic [IW-1:0]        first_free_reg;
    logic                 any_free_reg;
    logic [IW-1:0]        first_free_next;
    logic                 any_free_next;

    // Lowest clear bit of the taken vector; the result is registered so the
    // search sits alone between flops.
    always_comb
    begin
        first_free_next = '0;
        any_free_next   = 1'b0;
        for (int i = POOL_SIZE - 1; i >= 0; i--)
        begin
            if (!taken_reg[i])
            begin
                first_free_next = IW'(i);
                any_free_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg      <= '0;
            first_free_reg <= '0;
            any_free_reg   <= 1'b1;
        end
        else
        begin
            if (cmd.alloc)
            begin
                taken_reg[first_free_reg] <= 1'b1;
            end
            if (cmd.free)
            begin
                taken_reg[free_idx] <= 1'b0;
            end
            first_free_reg <= first_free_next;
            any_free_reg   <= any_free_next;
        end
    end

    assign first_free = first_free_reg;
    assign any_free   = any_free_reg;

endmodule

>>> src/process_slot_pool_ready_queue.sv
// ============================================================================
// process_slot_pool_ready_queue
// Pool of process slots with a FIFO ready queue linked through the slots.
// ============================================================================
//
//  Channel   Signals                          Carries
//  -------   -------------------------------  ------------------------------
//  input     in_valid, in_ready, in_data      action and slot, one word
//  output    out_valid, out_ready, out_data   slot_out and ok, one word
//
// Every word passes an accept cycle, which issues reads of the next and
// previous link memories, and an execute cycle, which uses the read data,
// writes back the neighbor links and loads the output register.
// A new word waits until the previous one has left the execute cycle, as
// the registered link reads must come ahead of the read-modify-write.
// Reset frees every slot and empties the queue at once; link valid bits live
// in flops, so no clearing pass is needed.
// A stalled output holds the execute cycle; a new word is accepted as soon as
// the previous one has moved into the output register.
//
module process_slot_pool_ready_queue #(
    parameter int POOL_SIZE = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  psprq_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output psprq_pkg::out_word_t out_data
);
    import psprq_pkg::*;

    localparam int IW = $clog2(POOL_SIZE);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    out_word_t  out_data_reg;
    action_t    act_reg;
    logic [IW-1:0] idx_reg;
    logic       inr_reg;

    // Queue pointers and per-slot link valid bits.
    logic [IW-1:0]        head_reg, head_next;
    logic [IW-1:0]        tail_reg, tail_next;
    logic                 empty_reg, empty_next;
    logic [POOL_SIZE-1:0] nvalid_reg, nvalid_next;
    logic [POOL_SIZE-1:0] pvalid_reg, pvalid_next;

    logic          accept;
    logic          fire;
    logic [IW-1:0] in_idx;
    logic          in_range;

    // Link memory ports.
    logic          n_we, p_we;
    logic [IW-1:0] n_waddr, p_waddr;
    logic [IW-1:0] n_wdata, p_wdata;
    logic [IW-1:0] n_raddr;
    logic [IW-1:0] nx, pv;

    // Taken-bit tracker.
    taken_cmd_t    tcmd;
    logic [IW-1:0] first_free;
    logic          any_free;

    logic          queued;
    out_word_t     res;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_idx   = IW'(in_data.slot);
    assign in_range = (32'(in_data.slot) < 32'(POOL_SIZE));

    // Pop reads the head's next link; release reads both links of its slot.
    assign n_raddr = (in_data.action == ACT_POP) ? head_reg : in_idx;

    psprq_link_ram #(
        .DEPTH (POOL_SIZE),
        .WIDTH (IW)
    ) u_next_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .re    (accept),
        .raddr (n_raddr),
        .rdata (nx)
    );

    psprq_link_ram #(
        .DEPTH (POOL_SIZE),
        .WIDTH (IW)
    ) u_prev_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (accept),
        .raddr (in_idx),
        .rdata (pv)
    );

    psprq_alloc #(
        .POOL_SIZE (POOL_SIZE)
    ) u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (tcmd),
        .free_idx   (idx_reg),
        .first_free (first_free),
        .any_free   (any_free)
    );

    // A slot is in the queue when it is the head or has a valid predecessor.
    assign queued = !empty_reg && ((head_reg == idx_reg) || pvalid_reg[idx_reg]);

    // Execute cycle: all updates are computed here and committed on fire.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        nvalid_next = nvalid_reg;
        pvalid_next = pvalid_reg;
        n_we        = 1'b0;
        n_waddr     = '0;
        n_wdata     = '0;
        p_we        = 1'b0;
        p_waddr     = '0;
        p_wdata     = '0;
        tcmd        = '0;
        res         = '0;

        if (fire)
        begin
            case (act_reg)
                ACT_ALLOC:
                begin
                    if (any_free)
                    begin
                        tcmd.alloc   = 1'b1;
                        res.slot_out = SLOT_W'(first_free);
                        res.ok       = 1'b1;
                    end
                end
                ACT_RELEASE:
                begin
                    if (inr_reg)
                    begin
                        tcmd.free = 1'b1;
                        res.ok    = 1'b1;
                        if (queued)
                        begin
                            if (nvalid_reg[idx_reg] && pvalid_reg[idx_reg])
                            begin
                                p_we    = 1'b1;
                                p_waddr = nx;
                                p_wdata = pv;
                                n_we    = 1'b1;
                                n_waddr = pv;
                                n_wdata = nx;
                            end
                            else if (nvalid_reg[idx_reg])
                            begin
                                head_next       = nx;
                                pvalid_next[nx] = 1'b0;
                            end
                            else if (pvalid_reg[idx_reg])
                            begin
                                tail_next       = pv;
                                nvalid_next[pv] = 1'b0;
                            end
                            else
                            begin
                                empty_next = 1'b1;
                                head_next  = '0;
                                tail_next  = '0;
                            end
                            nvalid_next[idx_reg] = 1'b0;
                            pvalid_next[idx_reg] = 1'b0;
                        end
                    end
                end
                ACT_APPEND:
                begin
                    if (inr_reg && !queued)
                    begin
                        res.ok               = 1'b1;
                        nvalid_next[idx_reg] = 1'b0;
                        pvalid_next[idx_reg] = 1'b0;
                        if (empty_reg)
                        begin
                            head_next  = idx_reg;
                            tail_next  = idx_reg;
                            empty_next = 1'b0;
                        end
                        else
                        begin
                            n_we                  = 1'b1;
                            n_waddr               = tail_reg;
                            n_wdata               = idx_reg;
                            nvalid_next[tail_reg] = 1'b1;
                            p_we                  = 1'b1;
                            p_waddr               = idx_reg;
                            p_wdata               = tail_reg;
                            pvalid_next[idx_reg]  = 1'b1;
                            tail_next             = idx_reg;
                        end
                    end
                end
                ACT_POP:
                begin
                    if (!empty_reg)
                    begin
                        res.slot_out = SLOT_W'(head_reg);
                        res.ok       = 1'b1;
                        nvalid_next[head_reg] = 1'b0;
                        pvalid_next[head_reg] = 1'b0;
                        if ((head_reg == tail_reg) || !nvalid_reg[head_reg])
                        begin
                            empty_next = 1'b1;
                            head_next  = '0;
                            tail_next  = '0;
                        end
                        else
                        begin
                            head_next       = nx;
                            pvalid_next[nx] = 1'b0;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            empty_reg  <= 1'b1;
            nvalid_reg <= '0;
            pvalid_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            empty_reg  <= empty_next;
            nvalid_reg <= nvalid_next;
            pvalid_reg <= pvalid_next;
        end
    end

    // Sequencer, held word and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            act_reg       <= ACT_ALLOC;
            idx_reg       <= '0;
            inr_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        act_reg   <= in_data.action;
                        idx_reg   <= in_idx;
                        inr_reg   <= in_range;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> src/psprq_checker.sv
// ============================================================================
// psprq_checker
// Port-level checks for the process slot pool and ready queue block.
// ============================================================================
module psprq_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input psprq_pkg::in_word_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input psprq_pkg::out_word_t out_data
);
    import psprq_pkg::*;

    // A waiting result word stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // A failed action reports slot zero.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.ok |-> out_data.slot_out == '0)
        else $error("nonzero slot on a failed action");

    // Only one word is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted during execute cycle");

    // A result is registered onto an empty output from the execute cycle, which is
    // entered only from an accept, so each rise of valid traces back to an accept.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a preceding accept");

endmodule

bind process_slot_pool_ready_queue psprq_checker u_psprq_checker (.*);
